// ----- hdl/line_rasterizer_4_connected_macros.svh -----
// Assertion helpers for the checker file of the line rasterizer.
`ifndef LINE_RASTERIZER_4_CONNECTED_MACROS_SVH
`define LINE_RASTERIZER_4_CONNECTED_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LR4C_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LR4C_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lr4c_pkg.sv -----
`default_nettype none

package lr4c_pkg;

	// Fixed widths of the address path and the stride register.
	localparam int ADDR_W   = 11;
	localparam int STRIDE_W = 7;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// Register map: word index of each register.
	localparam logic REG_ROW_STRIDE = 1'b0;

	// Stride value after reset.
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(40);

	// Depth of the command queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ----- hdl/lr4c_queue.sv -----
`default_nettype none

module lr4c_queue
	import lr4c_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_stall,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_stall,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// Handshake on both sides of the queue.
	assign push_stall = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;
	assign pop_data   = entry_q[rd_ptr_q];

	// Entry storage; only written entries are ever read.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lr4c_front.sv -----
`default_nettype none

module lr4c_front
	import lr4c_pkg::*;
#(
	parameter int COORD_BITS = 5,
	parameter int CMD_W      = 5 * COORD_BITS + 3
) (
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	output logic                       push_valid,
	input  wire logic                  push_stall,
	output logic      [CMD_W-1:0]      push_data
);

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] span_x;
		logic [COORD_BITS-1:0] span_y;
		logic                  x_neg;
		logic                  y_neg;
		logic [COORD_BITS:0]   steps;
	} cmd_t;

	cmd_t cmd;

	// Spans, directions and pixel count of the line.
	always_comb begin
		cmd.x0     = start_x;
		cmd.y0     = start_y;
		cmd.span_x = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
		cmd.span_y = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
		cmd.x_neg  = !(start_x < end_x);
		cmd.y_neg  = !(start_y < end_y);
		cmd.steps  = {1'b0, cmd.span_x} + {1'b0, cmd.span_y};
	end

	// A zero-length line is taken and dropped; others go into the queue.
	assign in_stall   = push_stall;
	assign push_valid = in_valid && (cmd.steps != '0);
	assign push_data  = cmd;

endmodule

`default_nettype wire

// ----- hdl/lr4c_back.sv -----
`default_nettype none

module lr4c_back
	import lr4c_pkg::*;
#(
	parameter int COORD_BITS = 5,
	parameter int CMD_W      = 5 * COORD_BITS + 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [STRIDE_W-1:0]   row_stride,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire logic [CMD_W-1:0]      cmd_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y,
	output logic      [ADDR_W-1:0]     pixel_address,
	output logic                       last_pixel
);

	localparam int ERR_W = COORD_BITS + 3;

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] span_x;
		logic [COORD_BITS-1:0] span_y;
		logic                  x_neg;
		logic                  y_neg;
		logic [COORD_BITS:0]   steps;
	} cmd_t;

	cmd_t                    cmd;
	logic                    busy_q;
	logic [COORD_BITS-1:0]   cur_x_q;
	logic [COORD_BITS-1:0]   cur_y_q;
	logic signed [ERR_W-1:0] err_q;
	logic [COORD_BITS:0]     steps_q;
	logic [COORD_BITS-1:0]   span_x_q;
	logic [COORD_BITS-1:0]   span_y_q;
	logic                    x_neg_q;
	logic                    y_neg_q;
	logic                    out_valid_q;
	logic [COORD_BITS-1:0]   pixel_x_q;
	logic [COORD_BITS-1:0]   pixel_y_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    last_q;

	logic                    advance;
	logic                    load;
	logic signed [ERR_W-1:0] err_x;
	logic signed [ERR_W-1:0] err_y;
	logic [ERR_W-1:0]        mag_x;
	logic [ERR_W-1:0]        mag_y;
	logic                    take_x;
	logic [ADDR_W-1:0]       addr_next;

	assign cmd       = cmd_t'(cmd_data);
	assign advance   = !out_valid_q || !out_stall;
	assign load      = !busy_q && cmd_valid;
	assign cmd_stall = busy_q;

	// Error terms for an x step and a y step, and the choice between them.
	always_comb begin
		err_x  = err_q + ERR_W'(span_y_q);
		err_y  = err_q - ERR_W'(span_x_q);
		mag_x  = err_x[ERR_W-1] ? ERR_W'(-err_x) : ERR_W'(err_x);
		mag_y  = err_y[ERR_W-1] ? ERR_W'(-err_y) : ERR_W'(err_y);
		take_x = (mag_x < mag_y);
	end

	// Buffer address of the current pixel, wrapped to the address width.
	assign addr_next = ADDR_W'(ADDR_W'(cur_y_q) * ADDR_W'(row_stride))
		+ ADDR_W'(cur_x_q);

	// Line stepper: loads a command while idle, then one pixel each cycle the output moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			err_q    <= '0;
			steps_q  <= '0;
			span_x_q <= '0;
			span_y_q <= '0;
			x_neg_q  <= 1'b0;
			y_neg_q  <= 1'b0;
		end else if (load) begin
			busy_q   <= 1'b1;
			cur_x_q  <= cmd.x0;
			cur_y_q  <= cmd.y0;
			err_q    <= '0;
			steps_q  <= cmd.steps;
			span_x_q <= cmd.span_x;
			span_y_q <= cmd.span_y;
			x_neg_q  <= cmd.x_neg;
			y_neg_q  <= cmd.y_neg;
		end else if (busy_q && advance) begin
			if (take_x) begin
				cur_x_q <= x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
				err_q   <= err_x;
			end else begin
				cur_y_q <= y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
				err_q   <= err_y;
			end
			steps_q <= steps_q - 1'b1;
			busy_q  <= (steps_q != (COORD_BITS + 1)'(1));
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			pixel_x_q <= cur_x_q;
			pixel_y_q <= cur_y_q;
			addr_q    <= addr_next;
			last_q    <= (steps_q == (COORD_BITS + 1)'(1));
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign pixel_address = addr_q;
	assign last_pixel    = last_q;

endmodule

`default_nettype wire

// ----- hdl/line_rasterizer_4_connected.sv -----
// 4-connected line rasterizer.
// An item on the input channel (in_valid/in_stall) is one line command from
// (start_x, start_y) to (end_x, end_y). The block emits dx+dy pixels on the
// output channel (out_valid/out_stall), starting at the start point and
// stopping one short of the end point; last_pixel marks the final one.
// A zero-length line is taken and produces no item.
// Each pixel carries pixel_address = pixel_x + pixel_y * row_stride, wrapped
// to 11 bits. row_stride is written through the APB port at address 0.
// The front classifies a command in the cycle it is taken and places it in a
// two-entry queue, so up to two commands wait while a line is drawn.
// The stepper loads a command from the queue while idle, then produces one
// pixel per cycle while the output is not stalled; a taken command passes
// through the queue, the stepper and the output register before its first pixel.
// When the receiver stalls, the output register holds its pixel and the
// stepper waits; the queue keeps taking commands until it is full.
// Reset clears the queue, the stepper and the output, and sets row_stride
// to 40.
`default_nettype none

module line_rasterizer_4_connected
	import lr4c_pkg::*;
#(
	parameter int COORD_BITS = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y,
	output logic      [ADDR_W-1:0]     pixel_address,
	output logic                       last_pixel
);

	localparam int CMD_W = 5 * COORD_BITS + 3;

	logic [STRIDE_W-1:0] row_stride_q;
	logic                push_valid;
	logic                push_stall;
	logic [CMD_W-1:0]    push_data;
	logic                cmd_valid;
	logic                cmd_stall;
	logic [CMD_W-1:0]    cmd_data;
	logic                reg_sel;

	// Configuration port: one register, word index in paddr[2].
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ROW_STRIDE);
	assign prdata  = reg_sel ? APB_DW'(row_stride_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= STRIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			row_stride_q <= pwdata[STRIDE_W-1:0];
		end
	end

	lr4c_front #(
		.COORD_BITS (COORD_BITS),
		.CMD_W      (CMD_W)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	lr4c_queue #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (cmd_valid),
		.pop_stall  (cmd_stall),
		.pop_data   (cmd_data)
	);

	lr4c_back #(
		.COORD_BITS (COORD_BITS),
		.CMD_W      (CMD_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.row_stride    (row_stride_q),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd_data      (cmd_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.last_pixel    (last_pixel)
	);

endmodule

`default_nettype wire

// ----- hdl/lr4c_checker.sv -----
`default_nettype none
`include "line_rasterizer_4_connected_macros.svh"

module lr4c_checker
	import lr4c_pkg::*;
#(
	parameter int COORD_BITS = 5
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COORD_BITS-1:0] pixel_x,
	input wire logic [COORD_BITS-1:0] pixel_y,
	input wire logic [ADDR_W-1:0]     pixel_address,
	input wire logic                  last_pixel
);

	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic                  step_x;
	logic                  step_y;
	logic                  adjacent;
	logic                  out_take;

	assign out_take = out_valid && !out_stall;

	// Last pixel handed over on the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (out_take) begin
			prev_x_q <= pixel_x;
			prev_y_q <= pixel_y;
		end
	end

	// Two pixels of one line differ by one step in exactly one axis.
	assign step_x   = (pixel_x == prev_x_q + 1'b1) || (pixel_x == prev_x_q - 1'b1);
	assign step_y   = (pixel_y == prev_y_q + 1'b1) || (pixel_y == prev_y_q - 1'b1);
	assign adjacent = (step_x && (pixel_y == prev_y_q)) || (step_y && (pixel_x == prev_x_q));

	`LR4C_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_address) && $stable(last_pixel), "stalled output item changed")
	`LR4C_ASSERT_NEXT(a_no_gap, out_take && !last_pixel, out_valid, "gap inside a line")
	`LR4C_ASSERT_SAME(a_adjacent, (out_take && !last_pixel) ##1 out_valid, adjacent, "pixels of a line are not 4-adjacent")

endmodule

bind line_rasterizer_4_connected lr4c_checker #(.COORD_BITS(COORD_BITS)) u_lr4c_checker (.*);

`default_nettype wire

// ----- tb/line_pixel_checker.sv -----
`default_nettype none

// Watches the line rasterizer's channels: traces every accepted line command
// into the pixels it must produce, then compares each pixel that leaves the
// block with the oldest one still owed.
module line_pixel_checker
	import lr4c_pkg::*;
#(
	parameter int COORD_BITS = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	input  wire logic [ADDR_W-1:0]     pixel_address,
	input  wire logic                  last_pixel,
	output int                         mismatch_count,
	output int                         pixels_owed
);

	// One pixel as the block should emit it.
	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [ADDR_W-1:0]     addr;
		logic                  last;
	} line_pixel_t;

	line_pixel_t           expected_pixels[$];
	logic [STRIDE_W-1:0]   row_stride = STRIDE_RESET;

	// Walks the 4-connected path of one line and queues its pixels. The error
	// term picks an x step only when that leaves it strictly closer to zero.
	function automatic void trace_line(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
		int          x;
		int          y;
		int          dx;
		int          dy;
		int          err;
		int          err_x;
		int          err_y;
		int          pixels_left;
		bit          x_back;
		bit          y_back;
		line_pixel_t px;
		x = int'(sx);
		y = int'(sy);
		dx = (int'(ex) >= int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
		dy = (int'(ey) >= int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
		x_back = !(sx < ex);
		y_back = !(sy < ey);
		err = 0;
		pixels_left = dx + dy;
		while (pixels_left != 0) begin
			px.col  = COORD_BITS'(x);
			px.row  = COORD_BITS'(y);
			px.addr = ADDR_W'(x + y * int'(row_stride));
			px.last = (pixels_left == 1);
			expected_pixels.push_back(px);
			err_x = err + dy;
			err_y = err - dx;
			if ((err_x < 0 ? -err_x : err_x) < (err_y < 0 ? -err_y : err_y)) begin
				x = x_back ? x - 1 : x + 1;
				err = err_x;
			end else begin
				y = y_back ? y - 1 : y + 1;
				err = err_y;
			end
			pixels_left--;
		end
	endfunction

	// Compare leaving pixels first, then queue the pixels of a new command and
	// follow writes to the stride register.
	always @(posedge clk or negedge arst_n) begin
		line_pixel_t px;
		if (!arst_n) begin
			expected_pixels.delete();
			row_stride = STRIDE_RESET;
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel (%0d, %0d) emitted with no pixel owed", pixel_x, pixel_y);
					mismatch_count++;
				end else begin
					px = expected_pixels.pop_front();
					if (pixel_x !== px.col) begin
						$error("pixel_x: expected %0d, got %0d", px.col, pixel_x);
						mismatch_count++;
					end
					if (pixel_y !== px.row) begin
						$error("pixel_y: expected %0d, got %0d", px.row, pixel_y);
						mismatch_count++;
					end
					if (pixel_address !== px.addr) begin
						$error("pixel_address: expected %0d, got %0d", px.addr,
							pixel_address);
						mismatch_count++;
					end
					if (last_pixel !== px.last) begin
						$error("last_pixel: expected %0d, got %0d", px.last, last_pixel);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				trace_line(start_x, start_y, end_x, end_y);
			end
			if (psel && penable && pwrite && pready &&
					paddr == APB_AW'(4 * REG_ROW_STRIDE)) begin
				row_stride = pwdata[STRIDE_W-1:0];
			end
		end
		pixels_owed = expected_pixels.size();
	end

endmodule

`default_nettype wire

// ----- tb/tb_line_rasterizer_4_connected.sv -----
`default_nettype none

module tb_line_rasterizer_4_connected;
	import lr4c_pkg::*;

	localparam int CW             = 5;
	localparam int COORD_MAX      = (1 << CW) - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_ITEMS    = 34;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	wire  [APB_DW-1:0] prdata;
	wire               pready;
	logic              in_valid = 1'b0;
	wire               in_stall;
	logic [CW-1:0]     start_x  = '0;
	logic [CW-1:0]     start_y  = '0;
	logic [CW-1:0]     end_x    = '0;
	logic [CW-1:0]     end_y    = '0;
	wire               out_valid;
	logic              out_stall = 1'b0;
	wire  [CW-1:0]     pixel_x;
	wire  [CW-1:0]     pixel_y;
	wire  [ADDR_W-1:0] pixel_address;
	wire               last_pixel;
	int                mismatch_count;
	int                pixels_owed;
	bit                steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_rasterizer_4_connected #(
		.COORD_BITS(CW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.last_pixel(last_pixel)
	);

	line_pixel_checker #(
		.COORD_BITS(CW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.last_pixel(last_pixel),
		.mismatch_count(mismatch_count),
		.pixels_owed(pixels_owed)
	);

	// The pixel receiver stalls now and then, except in the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 15);
	end

	// Offers one line command, sometimes after a short gap, and returns right
	// after the edge at which it is taken.
	task automatic send_line(input int sx, input int sy, input int ex, input int ey);
		if (!steady && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x  <= CW'(sx);
		start_y  <= CW'(sy);
		end_x    <= CW'(ex);
		end_y    <= CW'(ey);
		do @(posedge clk); while (in_stall);
	endtask

	// Holds off new commands until every owed pixel has left, then lets the
	// given number of cycles pass.
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		do @(negedge clk); while (pixels_owed != 0);
		@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Setup and access phase of one write to the stride register.
	task automatic write_stride(input logic [STRIDE_W-1:0] stride);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * REG_ROW_STRIDE);
		pwdata  <= APB_DW'(stride);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A coordinate within a few pixels of the given one, kept on the grid.
	function automatic int near_coord(input int c);
		int v;
		v = c + int'($urandom_range(0, 12)) - 6;
		return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
	endfunction

	// Watchdog: gives up when nothing moves on any port for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus: directed lines at the reset stride, then one random phase per
	// stride setting.
	initial begin
		logic [STRIDE_W-1:0] stride_plan[PHASE_COUNT];
		int                  sx;
		int                  sy;
		int                  ex;
		int                  ey;
		int                  kind;
		stride_plan[0] = STRIDE_W'(1);
		stride_plan[1] = STRIDE_W'(64);
		stride_plan[2] = STRIDE_W'(0);
		stride_plan[3] = STRIDE_W'(127);
		stride_plan[4] = STRIDE_W'($urandom_range(1, 64));
		stride_plan[5] = STRIDE_W'($urandom_range(0, 127));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-length lines, full diagonals both ways, axis lines, ties and
		// one-pixel lines.
		send_line(0, 0, 0, 0);
		send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_line(0, 0, COORD_MAX, COORD_MAX);
		send_line(COORD_MAX, COORD_MAX, 0, 0);
		send_line(0, COORD_MAX, COORD_MAX, 0);
		send_line(COORD_MAX, 0, 0, COORD_MAX);
		send_line(0, 5, COORD_MAX, 5);
		send_line(COORD_MAX, 5, 0, 5);
		send_line(7, 0, 7, COORD_MAX);
		send_line(7, COORD_MAX, 7, 0);
		send_line(0, 0, 1, 1);
		send_line(0, 0, 2, 1);
		send_line(0, 0, 1, 2);
		send_line(3, 3, 4, 3);
		send_line(3, 3, 3, 2);
		send_line(0, 0, COORD_MAX, 1);
		send_line(0, 0, 1, COORD_MAX);
		send_line(21, 10, 10, 21);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain(SETTLE_CYCLES);
			write_stride(stride_plan[phase]);
			steady = (phase == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Sender waits for the block to empty in the middle of some phases.
				if (phase % 2 == 1 && k == PHASE_ITEMS / 2) begin
					drain(0);
				end
				kind = $urandom_range(0, 99);
				sx = $urandom_range(0, COORD_MAX);
				sy = $urandom_range(0, COORD_MAX);
				ex = $urandom_range(0, COORD_MAX);
				ey = $urandom_range(0, COORD_MAX);
				if (kind < 55) begin
					// Mostly short lines keep the run quick.
					ex = near_coord(sx);
					ey = near_coord(sy);
				end else if (kind < 82) begin
					// Fully random end points.
				end else if (kind < 88) begin
					ey = sy;
				end else if (kind < 93) begin
					ex = sx;
				end else if (kind < 96) begin
					ex = sx;
					ey = sy;
				end else begin
					// Corner to corner.
					sx = $urandom_range(0, 1) * COORD_MAX;
					sy = $urandom_range(0, 1) * COORD_MAX;
					ex = $urandom_range(0, 1) * COORD_MAX;
					ey = $urandom_range(0, 1) * COORD_MAX;
				end
				send_line(sx, sy, ex, ey);
			end
		end
		steady = 1'b0;

		drain(SETTLE_CYCLES);
		if (mismatch_count == 0 && pixels_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/lr4c_pkg.sv
hdl/lr4c_queue.sv
hdl/lr4c_front.sv
hdl/lr4c_back.sv
hdl/line_rasterizer_4_connected.sv
hdl/lr4c_checker.sv
tb/line_pixel_checker.sv
tb/tb_line_rasterizer_4_connected.sv
